[rtl/core/assert_macros.svh]
// assertion macros shared by the rtl of the sorted adjacency list builder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// checked on clk_i, ignored while rst_ni is low
`define SAL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");

// checked on clk_i at every edge, reset included
`define SAL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("%m: check failed");

`else

`define SAL_ASSERT(lbl, prop)
`define SAL_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

[rtl/core/sal_pkg.sv]
// types and constants of the sorted adjacency list builder
`default_nettype none

package sal_pkg;

  localparam int FIELD_W = 10;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [FIELD_W-1:0] VCOUNT_RESET = 10'd1023;

  // register index, taken from paddr above the byte offset
  localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [FIELD_W-1:0] vertex;
    logic [FIELD_W-1:0] neighbor;
  } sal_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] neighbor_out;
    logic               list_empty;
    logic               last;
    logic [1:0]         status;
  } sal_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DEG,
    ST_INS_RD,
    ST_INS_CMP,
    ST_RD_ISSUE,
    ST_RD_DATA,
    ST_EMIT
  } sal_state_e;

endpackage

`default_nettype wire

[rtl/core/sal_ram.sv]
// generic simple dual port ram with registered read
`default_nettype none

module sal_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/sorted_adjacency_list_builder.sv]
// top level of the sorted adjacency list builder: sequencer, registers and the two rams
//
// usage: one input beat on in_data_i (action, vertex, neighbor) starts one command;
// in_stall_o is low only while the sequencer is idle, so one command runs at a time.
// clear gives no result; insert and out-of-range commands give one result beat;
// a read gives one beat per stored neighbor in ascending order, last set on the final one,
// or a single beat with list_empty set for an empty list.
// an out-of-range vertex goes straight to the emit step; other inserts and reads first fetch
// the degree count, then a full list or an empty read goes to emit, an insert alternates read
// and compare steps while it moves each larger entry up one slot, and a read issues, fetches
// and emits each neighbor in turn.
// inserts share the single neighbor ram port pair and the one compare unit: each larger
// entry of the row is read, compared and written back one slot up in its own steps.
// clear: one degree-count ram entry per cycle, all VERTICES entries in turn.
// after reset the same clearing pass runs before the first beat is taken;
// configuration writes over the apb port are taken at any time and take effect at once.
// results sit in an output register; while out_stall_i is high it holds its beat and the
// sequencer waits at its next result, but a finished command frees the input side.
`default_nettype none
`include "assert_macros.svh"

module sorted_adjacency_list_builder #(
  parameter int VERTICES   = 1024,
  parameter int MAX_DEGREE = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // command channel
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire sal_pkg::sal_in_t                  in_data_i,
  // result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output sal_pkg::sal_out_t                      out_data_o,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [sal_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [sal_pkg::PDATA_W-1:0]       pwdata,
  output logic      [sal_pkg::PDATA_W-1:0]       prdata,
  output logic                                   pready
);

  import sal_pkg::*;

  localparam int VI_W     = $clog2(VERTICES);
  localparam int SLOT_W   = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int CNT_W    = $clog2(MAX_DEGREE + 1);
  localparam int NB_DEPTH = VERTICES * (2 ** SLOT_W);
  localparam int NB_AW    = VI_W + SLOT_W;

  sal_state_e         state_q, state_d;
  sal_in_t            req_q, req_d;
  logic [VI_W-1:0]    vidx_q, vidx_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [VI_W-1:0]    clr_q, clr_d;
  sal_out_t           resp_q, resp_d;
  sal_out_t           out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic [FIELD_W-1:0] vcount_q, vcount_d;

  logic               in_accept;
  logic               slot_free;
  logic               out_load;
  logic               vtx_ok;
  logic [CNT_W-1:0]   idx_m1;
  logic               nb_greater;

  logic               deg_we, deg_re;
  logic [VI_W-1:0]    deg_waddr, deg_raddr;
  logic [CNT_W-1:0]   deg_wdata, deg_rdata;
  logic               nb_we, nb_re;
  logic [NB_AW-1:0]   nb_waddr, nb_raddr;
  logic [FIELD_W-1:0] nb_wdata, nb_rdata;

  sal_ram #(
    .WIDTH (CNT_W),
    .DEPTH (VERTICES)
  ) u_deg_ram (
    .clk_i   (clk_i),
    .we_i    (deg_we),
    .waddr_i (deg_waddr),
    .wdata_i (deg_wdata),
    .re_i    (deg_re),
    .raddr_i (deg_raddr),
    .rdata_o (deg_rdata)
  );

  sal_ram #(
    .WIDTH (FIELD_W),
    .DEPTH (NB_DEPTH)
  ) u_nb_ram (
    .clk_i   (clk_i),
    .we_i    (nb_we),
    .waddr_i (nb_waddr),
    .wdata_i (nb_wdata),
    .re_i    (nb_re),
    .raddr_i (nb_raddr),
    .rdata_o (nb_rdata)
  );

  // configuration register
  always_comb begin
    vcount_d = vcount_q;
    if (psel && penable && pwrite && pready &&
        paddr[PADDR_W-1:2] == REG_VERTEX_COUNT) begin
      vcount_d = pwdata[FIELD_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_VERTEX_COUNT) ? PDATA_W'(vcount_q) : '0;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;

  assign vtx_ok = (in_data_i.vertex != '0) && (in_data_i.vertex <= vcount_q) &&
                  (32'(in_data_i.vertex) < VERTICES);

  // compare unit: stored entry against the neighbor being inserted
  assign nb_greater = nb_rdata > req_q.neighbor;
  assign idx_m1     = idx_q - CNT_W'(1);

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    vidx_d    = vidx_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    clr_d     = clr_q;
    resp_d    = resp_q;
    out_load  = 1'b0;
    deg_we    = 1'b0;
    deg_waddr = vidx_q;
    deg_wdata = cnt_q + CNT_W'(1);
    deg_re    = 1'b0;
    deg_raddr = VI_W'(in_data_i.vertex);
    nb_we     = 1'b0;
    nb_waddr  = {vidx_q, idx_q[SLOT_W-1:0]};
    nb_wdata  = req_q.neighbor;
    nb_re     = 1'b0;
    nb_raddr  = {vidx_q, idx_m1[SLOT_W-1:0]};

    case (state_q)
      ST_CLEAR: begin
        deg_we    = 1'b1;
        deg_waddr = clr_q;
        deg_wdata = '0;
        clr_d     = clr_q + VI_W'(1);
        if (clr_q == VI_W'(VERTICES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          req_d  = in_data_i;
          vidx_d = VI_W'(in_data_i.vertex);
          case (in_data_i.action)
            ACT_CLEAR: begin
              clr_d   = '0;
              state_d = ST_CLEAR;
            end
            ACT_INSERT, ACT_READ: begin
              if (!vtx_ok) begin
                resp_d  = '{neighbor_out: '0, list_empty: 1'b0, last: 1'b1,
                            status: STAT_RANGE};
                state_d = ST_EMIT;
              end else begin
                deg_re  = 1'b1;
                state_d = ST_DEG;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_DEG: begin
        cnt_d = deg_rdata;
        if (req_q.action == ACT_INSERT) begin
          idx_d = deg_rdata;
          if (32'(deg_rdata) >= MAX_DEGREE) begin
            resp_d  = '{neighbor_out: '0, list_empty: 1'b0, last: 1'b1,
                        status: STAT_FULL};
            state_d = ST_EMIT;
          end else begin
            state_d = ST_INS_RD;
          end
        end else begin
          idx_d = '0;
          if (deg_rdata == '0) begin
            resp_d  = '{neighbor_out: '0, list_empty: 1'b1, last: 1'b1,
                        status: STAT_OK};
            state_d = ST_EMIT;
          end else begin
            state_d = ST_RD_ISSUE;
          end
        end
      end
      ST_INS_RD: begin
        if (idx_q == '0) begin
          // reached the head of the row: the new neighbor goes first
          nb_we   = 1'b1;
          deg_we  = 1'b1;
          resp_d  = '{neighbor_out: '0, list_empty: 1'b0, last: 1'b1, status: STAT_OK};
          state_d = ST_EMIT;
        end else begin
          nb_re   = 1'b1;
          state_d = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        nb_we = 1'b1;
        if (nb_greater) begin
          // move the larger entry up one slot and keep scanning down
          nb_wdata = nb_rdata;
          idx_d    = idx_m1;
          state_d  = ST_INS_RD;
        end else begin
          deg_we  = 1'b1;
          resp_d  = '{neighbor_out: '0, list_empty: 1'b0, last: 1'b1, status: STAT_OK};
          state_d = ST_EMIT;
        end
      end
      ST_RD_ISSUE: begin
        nb_re    = 1'b1;
        nb_raddr = {vidx_q, idx_q[SLOT_W-1:0]};
        state_d  = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        resp_d  = '{neighbor_out: nb_rdata, list_empty: 1'b0,
                    last: ((idx_q + CNT_W'(1)) == cnt_q), status: STAT_OK};
        idx_d   = idx_q + CNT_W'(1);
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = resp_q.last ? ST_IDLE : ST_RD_ISSUE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_d       = resp_q;
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      vcount_q    <= VCOUNT_RESET;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      vcount_q    <= vcount_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    vidx_q <= vidx_d;
    cnt_q  <= cnt_d;
    idx_q  <= idx_d;
    resp_q <= resp_d;
    out_q  <= out_d;
  end

  // a new result beat only comes from the emit step
  `SAL_ASSERT(a_out_from_emit, $rose(out_valid_q) |-> $past(state_q) == ST_EMIT)
  // the insert scan stays inside the occupied part of the row
  `SAL_ASSERT(a_ins_idx_range, state_q == ST_INS_CMP |-> idx_q != '0 && idx_q <= cnt_q)
  // a read never addresses beyond the stored count
  `SAL_ASSERT(a_rd_idx_range, state_q == ST_RD_ISSUE |-> idx_q < cnt_q)
  // a degree update never exceeds the row size
  `SAL_ASSERT(a_deg_bound, deg_we && state_q != ST_CLEAR |-> 32'(deg_wdata) <= MAX_DEGREE)
  // the last beat of a command returns the sequencer to idle
  `SAL_ASSERT(a_last_to_idle, state_q == ST_EMIT && slot_free && resp_q.last |=>
              state_q == ST_IDLE)

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// self-checking testbench of the sorted adjacency list builder
`default_nettype none

module tb;
  import sal_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int VERTICES       = 1024;
  localparam int MAX_DEGREE     = 32;
  localparam int SETTLE_CYCLES  = VERTICES + 200;
  localparam int LONG_HOLD      = 400;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int REPORT_LIMIT   = 10;

  // the one action code the block ignores
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  class adjacency_predictor;
    bit [FIELD_W-1:0] rows [VERTICES][MAX_DEGREE];
    int unsigned      degree [VERTICES];
    bit [FIELD_W-1:0] vcount;
    sal_out_t         expected_beats [$];
    int unsigned      mismatches;
    int unsigned      cmds_seen;
    int unsigned      beats_seen;
    int unsigned      full_beats;
    int unsigned      range_beats;
    int unsigned      empty_beats;

    function new();
      vcount = VCOUNT_RESET;
      foreach (degree[i]) degree[i] = 0;
    endfunction

    function bit vertex_valid(bit [FIELD_W-1:0] v);
      return v >= 1 && v <= vcount && int'(v) < VERTICES;
    endfunction

    function void push_beat(bit [FIELD_W-1:0] nb, bit empty, bit last, logic [1:0] status);
      sal_out_t b;
      b.neighbor_out = nb;
      b.list_empty   = empty;
      b.last         = last;
      b.status       = status;
      if (status == STAT_FULL) full_beats++;
      if (status == STAT_RANGE) range_beats++;
      if (empty) empty_beats++;
      expected_beats.push_back(b);
    endfunction

    function void apply_cmd(sal_in_t c);
      int unsigned cnt;
      int unsigned pos;
      cmds_seen++;
      case (c.action)
        ACT_CLEAR: begin
          foreach (degree[i]) degree[i] = 0;
        end
        ACT_INSERT: begin
          if (!vertex_valid(c.vertex)) begin
            push_beat('0, 1'b0, 1'b1, STAT_RANGE);
          end else if (degree[c.vertex] >= MAX_DEGREE) begin
            push_beat('0, 1'b0, 1'b1, STAT_FULL);
          end else begin
            cnt = degree[c.vertex];
            pos = 0;
            // equal neighbors stay in arrival order
            while (pos < cnt && rows[c.vertex][pos] <= c.neighbor) pos++;
            for (int i = cnt; i > pos; i--) rows[c.vertex][i] = rows[c.vertex][i-1];
            rows[c.vertex][pos] = c.neighbor;
            degree[c.vertex] = cnt + 1;
            push_beat('0, 1'b0, 1'b1, STAT_OK);
          end
        end
        ACT_READ: begin
          if (!vertex_valid(c.vertex)) begin
            push_beat('0, 1'b0, 1'b1, STAT_RANGE);
          end else if (degree[c.vertex] == 0) begin
            push_beat('0, 1'b1, 1'b1, STAT_OK);
          end else begin
            cnt = degree[c.vertex];
            for (int i = 0; i < cnt; i++)
              push_beat(rows[c.vertex][i], 1'b0, (i + 1 == cnt), STAT_OK);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_beat(sal_out_t got);
      sal_out_t want;
      beats_seen++;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result beat: nb %0d empty %0b last %0b status %0d",
                   got.neighbor_out, got.list_empty, got.last, got.status);
        return;
      end
      want = expected_beats.pop_front();
      if (got.neighbor_out !== want.neighbor_out || got.list_empty !== want.list_empty ||
          got.last !== want.last || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("result beat %0d: expected nb %0d empty %0b last %0b status %0d",
                   beats_seen, want.neighbor_out, want.list_empty, want.last, want.status);
          $display("  got nb %0d empty %0b last %0b status %0d",
                   got.neighbor_out, got.list_empty, got.last, got.status);
        end
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  sal_in_t             in_data;
  logic                out_valid;
  logic                out_stall;
  sal_out_t            out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  adjacency_predictor  sb;
  int                  idle_mode;
  bit                  rx_hold_req;
  int                  rx_hold_left;
  int                  reg_writes;

  sorted_adjacency_list_builder #(
    .VERTICES   (VERTICES),
    .MAX_DEGREE (MAX_DEGREE)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d result beats outstanding", sb.expected_beats.size());
    $display("end of test: mismatches");
    $finish;
  end

  // mode 0: sender idles often, receiver more; mode 1: the reverse; mode 2: no idling
  function automatic bit tx_idle();
    case (idle_mode)
      0:       return $urandom_range(0, 99) < 34;
      1:       return $urandom_range(0, 99) < 65;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit rx_idle();
    case (idle_mode)
      0:       return $urandom_range(0, 99) < 65;
      1:       return $urandom_range(0, 99) < 34;
      default: return 1'b0;
    endcase
  endfunction

  // result side: beats are taken on edges where valid is high and stall was low
  initial begin
    out_stall <= 1'b0;
    rx_hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_n && out_valid && !out_stall) sb.check_beat(out_data);
      if (rx_hold_req) begin
        rx_hold_left = LONG_HOLD;
        rx_hold_req  = 1'b0;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= rx_idle();
      end
    end
  end

  function automatic sal_in_t make_cmd(logic [1:0] act, int unsigned v, int unsigned nb);
    sal_in_t c;
    c.action   = act;
    c.vertex   = FIELD_W'(v);
    c.neighbor = FIELD_W'(nb);
    return c;
  endfunction

  task automatic send_cmd(input sal_in_t c);
    while (tx_idle()) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.apply_cmd(c);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk_i);
  endtask

  // a clear gives no result, so wait out its sweep before touching the register
  task automatic write_vertex_count(input int unsigned value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_VERTEX_COUNT, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.vcount = FIELD_W'(value);
    reg_writes++;
  endtask

  // mostly well-formed traffic on a few hot vertices, plus range edges and noise
  function automatic sal_in_t random_cmd(int unsigned clr_pct, int unsigned ins_pct,
                                         int unsigned hot);
    sal_in_t     c;
    int unsigned r;
    int unsigned s;
    r = $urandom_range(0, 99);
    s = $urandom_range(0, 99);
    c.neighbor = FIELD_W'($urandom);
    if (r < clr_pct) c.action = ACT_CLEAR;
    else if (r < clr_pct + 3) c.action = ACT_UNUSED;
    else if (r < clr_pct + 3 + ins_pct) c.action = ACT_INSERT;
    else c.action = ACT_READ;
    if (s < 80) c.vertex = FIELD_W'($urandom_range(1, hot));
    else if (s < 88) c.vertex = sb.vcount;
    else if (s < 94) c.vertex = sb.vcount + 1'b1;
    else c.vertex = FIELD_W'($urandom);
    return c;
  endfunction

  task automatic run_random(input int n, input int unsigned clr_pct,
                            input int unsigned ins_pct, input int unsigned hot,
                            input int pause_at);
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) drain_results();
      send_cmd(random_cmd(clr_pct, ins_pct, hot));
    end
  endtask

  initial begin
    sb = new();
    idle_mode   = 0;
    rx_hold_req = 1'b0;
    reg_writes  = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed part with the reset vertex count
    send_cmd(make_cmd(ACT_READ, 1, 0));
    send_cmd(make_cmd(ACT_READ, 0, 0));
    send_cmd(make_cmd(ACT_INSERT, 0, 5));
    send_cmd(make_cmd(ACT_INSERT, 1023, 1023));
    send_cmd(make_cmd(ACT_INSERT, 1023, 0));
    send_cmd(make_cmd(ACT_READ, 1023, 0));
    send_cmd(make_cmd(ACT_INSERT, 1, 512));
    send_cmd(make_cmd(ACT_INSERT, 1, 0));
    send_cmd(make_cmd(ACT_INSERT, 1, 1023));
    send_cmd(make_cmd(ACT_INSERT, 1, 512));
    send_cmd(make_cmd(ACT_INSERT, 1, 511));
    send_cmd(make_cmd(ACT_INSERT, 1, 1023));
    send_cmd(make_cmd(ACT_READ, 1, 0));
    send_cmd(make_cmd(ACT_UNUSED, 1, 7));
    send_cmd(make_cmd(ACT_READ, 1, 0));
    send_cmd(make_cmd(ACT_CLEAR, 0, 0));
    send_cmd(make_cmd(ACT_READ, 1, 0));
    send_cmd(make_cmd(ACT_READ, 1023, 0));
    send_cmd(make_cmd(ACT_INSERT, 2, 341));
    send_cmd(make_cmd(ACT_INSERT, 2, 682));
    send_cmd(make_cmd(ACT_READ, 2, 0));

    // one vertex only: its list fills and further edges are dropped
    write_vertex_count(1);
    run_random(60, 0, 80, 1, -1);

    // no vertex in range
    idle_mode = 1;
    write_vertex_count(0);
    run_random(12, 5, 45, 3, -1);

    // receiver holds off long enough for the block to back up
    write_vertex_count(7);
    rx_hold_req = 1'b1;
    run_random(45, 3, 60, 7, -1);

    idle_mode = 2;
    write_vertex_count(1023);
    run_random(30, 3, 60, 6, 15);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("ran %0d commands over %0d vertex-count settings, checked %0d result beats",
             sb.cmds_seen, reg_writes + 1, sb.beats_seen);
    $display("dropped full-list edges %0d, out-of-range beats %0d, empty reads %0d",
             sb.full_beats, sb.range_beats, sb.empty_beats);
    if (sb.expected_beats.size() != 0)
      $display("%0d expected result beats never arrived", sb.expected_beats.size());
    if (sb.mismatches == 0 && sb.expected_beats.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
